>>> hw/rtl/hmc_pkg.sv
package hmc_pkg;

    localparam int MAX_ROWS      = 256;
    localparam int MAX_ROW_BYTES = 64;
    // Addresses wrap by truncation, so the store depth is kept a power of two.
    localparam int STORE_DEPTH   = MAX_ROWS * MAX_ROW_BYTES;

    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int STRIDE_W   = $clog2(MAX_ROW_BYTES + 1);
    localparam int COL_W      = 6;
    localparam int IND_W      = 7;
    localparam int SITE_W     = 9;
    localparam int CFG_W      = 7;
    localparam int COUNT_W    = 10;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic clear;
        logic load_a;
        logic accum;
    } hmc_count_ctrl_t;

endpackage

>>> hw/rtl/hmc_store.sv
module hmc_store
    import hmc_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr0,
    input  logic [ADDR_W-1:0] rd_addr1,
    output logic [7:0]        rd_data0,
    output logic [7:0]        rd_data1
);

    logic [7:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data0 <= mem[rd_addr0];
        rd_data1 <= mem[rd_addr1];
    end

endmodule

>>> hw/rtl/hmc_addr_unit.sv
module hmc_addr_unit
    import hmc_pkg::*;
(
    input  logic [ROW_W-1:0]    row,
    input  logic [STRIDE_W-1:0] stride,
    input  logic [COL_W-1:0]    col,
    output logic [ADDR_W-1:0]   addr
);

    localparam int SUM_W = ROW_W + STRIDE_W + 1;

    logic [ROW_W+STRIDE_W-1:0] product;
    logic [SUM_W-1:0]          sum;

    assign product = row * stride;
    assign sum     = SUM_W'(product) + SUM_W'(col);
    // Wrap around the flat store.
    assign addr    = sum[ADDR_W-1:0];

endmodule

>>> hw/rtl/hmc_count_unit.sv
module hmc_count_unit
    import hmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  hmc_count_ctrl_t     ctrl,
    input  logic [7:0]          rd_data0,
    input  logic [7:0]          rd_data1,
    output logic [COUNT_W-1:0]  het_sum,
    output logic [COUNT_W-1:0]  mis_sum
);

    function automatic logic [3:0] ones8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    logic [7:0]         mask_a_reg;
    logic [7:0]         mask_b;
    logic [COUNT_W-1:0] het_reg;
    logic [COUNT_W-1:0] mis_reg;

    assign mask_b = rd_data0 ^ rd_data1;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            mask_a_reg <= rd_data0 ^ rd_data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            het_reg <= '0;
            mis_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            het_reg <= '0;
            mis_reg <= '0;
        end
        else if (ctrl.accum)
        begin
            het_reg <= het_reg + COUNT_W'(ones8(mask_a_reg | mask_b));
            mis_reg <= mis_reg + COUNT_W'(ones8(mask_a_reg ^ mask_b));
        end
    end

    assign het_sum = het_reg;
    assign mis_sum = mis_reg;

endmodule

>>> hw/rtl/het_mismatch_counter.sv
// channel | handshake           | payload
// in      | in_valid, in_ready  | req_type, row_index, byte_column, byte_value,
//         |                     | first_individual, second_individual, start_site, stop_site
// out     | out_valid, out_ready| het_count, mismatch_count, range_error
// cfg     | cfg_valid, cfg_ready| cfg_data (row_stride_bytes)
//
// A write item is accepted in ST_IDLE, then written to the store at row*stride+column in ST_WRITE.
// A query over N bytes runs 4 address setups through the shared multiply-add, then
// per byte one two-port store read for each individual, then drain and result.
// A reversed range goes straight to the result and reads nothing.
// rst_n clears control and sets the stride to 64; the store holds no reset.
// A result waits in the output register; a later result holds until it is taken.
module het_mismatch_counter
    import hmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [ROW_W-1:0]    row_index,
    input  logic [COL_W-1:0]    byte_column,
    input  logic [7:0]          byte_value,
    input  logic [IND_W-1:0]    first_individual,
    input  logic [IND_W-1:0]    second_individual,
    input  logic [SITE_W-1:0]   start_site,
    input  logic [SITE_W-1:0]   stop_site,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COUNT_W-1:0]  het_count,
    output logic [COUNT_W-1:0]  mismatch_count,
    output logic                range_error,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STATE_W-1:0] ST_WRITE = 3'd1;
    localparam logic [STATE_W-1:0] ST_SETUP = 3'd2;
    localparam logic [STATE_W-1:0] ST_RUN   = 3'd3;
    localparam logic [STATE_W-1:0] ST_DRAIN = 3'd4;
    localparam logic [STATE_W-1:0] ST_DONE  = 3'd5;

    logic [STATE_W-1:0]  state_reg, state_next;
    logic [1:0]          setup_cnt_reg, setup_cnt_next;
    logic                phase_reg, phase_next;
    logic [COL_W-1:0]    bytes_left_reg, bytes_left_next;
    logic                issued_a_reg, issued_a_next;
    logic                issued_b_reg, issued_b_next;
    logic                out_valid_reg, out_valid_next;
    logic [STRIDE_W-1:0] stride_reg;

    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [7:0]          wdata_reg;
    logic [IND_W-1:0]    ind_a_reg;
    logic [IND_W-1:0]    ind_b_reg;
    logic                err_reg;
    logic [ADDR_W-1:0]   ptr_reg [4];

    logic [COUNT_W-1:0]  het_out_reg;
    logic [COUNT_W-1:0]  mis_out_reg;
    logic                err_out_reg;

    logic                in_accept;
    logic                query_accept;
    logic                load_out;
    logic [COL_W-1:0]    first_byte;
    logic [COL_W-1:0]    last_byte;

    logic [ROW_W-1:0]    au_row;
    logic [COL_W-1:0]    au_col;
    logic [ADDR_W-1:0]   au_addr;

    logic [ADDR_W-1:0]   rd_addr0;
    logic [ADDR_W-1:0]   rd_addr1;
    logic [7:0]          rd_data0;
    logic [7:0]          rd_data1;

    hmc_count_ctrl_t     count_ctrl;
    logic [COUNT_W-1:0]  het_sum;
    logic [COUNT_W-1:0]  mis_sum;

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_accept    = in_valid && in_ready;
    assign query_accept = in_accept && (req_type == REQ_QUERY);
    assign first_byte   = start_site[SITE_W-1:3];
    assign last_byte    = stop_site[SITE_W-1:3];
    assign load_out     = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign cfg_ready    = 1'b1;

    // Clamp the stride into 1..MAX_ROW_BYTES.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= STRIDE_W'(MAX_ROW_BYTES);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_data == '0)
            begin
                stride_reg <= STRIDE_W'(1);
            end
            else if (int'(cfg_data) > MAX_ROW_BYTES)
            begin
                stride_reg <= STRIDE_W'(MAX_ROW_BYTES);
            end
            else
            begin
                stride_reg <= STRIDE_W'(cfg_data);
            end
        end
    end

    // Shared address unit: write address, or one of the four row bases.
    always_comb
    begin
        au_row = row_reg;
        au_col = col_reg;
        if (state_reg == ST_SETUP)
        begin
            au_col = col_reg;
            case (setup_cnt_reg)
                2'd0:    au_row = {ind_a_reg, 1'b0};
                2'd1:    au_row = {ind_a_reg, 1'b1};
                2'd2:    au_row = {ind_b_reg, 1'b0};
                default: au_row = {ind_b_reg, 1'b1};
            endcase
        end
    end

    hmc_addr_unit u_addr (
        .row    (au_row),
        .stride (stride_reg),
        .col    (au_col),
        .addr   (au_addr)
    );

    assign rd_addr0 = phase_reg ? ptr_reg[2] : ptr_reg[0];
    assign rd_addr1 = phase_reg ? ptr_reg[3] : ptr_reg[1];

    hmc_store u_store (
        .clk      (clk),
        .wr_en    (state_reg == ST_WRITE),
        .wr_addr  (au_addr),
        .wr_data  (wdata_reg),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    assign count_ctrl.clear  = query_accept;
    assign count_ctrl.load_a = issued_a_reg;
    assign count_ctrl.accum  = issued_b_reg;

    hmc_count_unit u_count (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (count_ctrl),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1),
        .het_sum  (het_sum),
        .mis_sum  (mis_sum)
    );

    always_comb
    begin
        state_next      = state_reg;
        setup_cnt_next  = setup_cnt_reg;
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        issued_a_next   = (state_reg == ST_RUN) && !phase_reg;
        issued_b_next   = (state_reg == ST_RUN) && phase_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type == REQ_WRITE)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (stop_site < start_site)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next      = ST_SETUP;
                        setup_cnt_next  = 2'd0;
                        phase_next      = 1'b0;
                        bytes_left_next = last_byte - first_byte;
                    end
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_SETUP:
            begin
                setup_cnt_next = setup_cnt_reg + 2'd1;
                if (setup_cnt_reg == 2'd3)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (bytes_left_reg == '0)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - COL_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            setup_cnt_reg  <= 2'd0;
            phase_reg      <= 1'b0;
            bytes_left_reg <= '0;
            issued_a_reg   <= 1'b0;
            issued_b_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            setup_cnt_reg  <= setup_cnt_next;
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            issued_a_reg   <= issued_a_next;
            issued_b_reg   <= issued_b_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Item capture, row pointers and result register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            row_reg   <= row_index;
            wdata_reg <= byte_value;
            ind_a_reg <= first_individual;
            ind_b_reg <= second_individual;
            err_reg   <= (req_type == REQ_QUERY) && (stop_site < start_site);
            col_reg   <= (req_type == REQ_WRITE) ? byte_column : first_byte;
        end
        if (state_reg == ST_SETUP)
        begin
            ptr_reg[setup_cnt_reg] <= au_addr;
        end
        // Advance all four rows to the next byte once both individuals are read.
        if ((state_reg == ST_RUN) && phase_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ptr_reg[i] <= ptr_reg[i] + ADDR_W'(1);
            end
        end
        if (load_out)
        begin
            het_out_reg <= het_sum;
            mis_out_reg <= mis_sum;
            err_out_reg <= err_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign het_count      = het_out_reg;
    assign mismatch_count = mis_out_reg;
    assign range_error    = err_out_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> (het_count == '0) && (mismatch_count == '0))
        else $error("range error result carries nonzero counts");

    a_mis_le_het: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mismatch_count <= het_count))
        else $error("mismatch count exceeds het count");

    a_load_accum_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(issued_a_reg && issued_b_reg))
        else $error("mask load and accumulate in the same cycle");

    a_drain_accum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> issued_b_reg)
        else $error("drain without pending second-individual read");

endmodule

>>> dv/het_mismatch_counter_checker.sv
module het_mismatch_counter_checker
    import hmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                req_type,
    input  logic [ROW_W-1:0]    row_index,
    input  logic [COL_W-1:0]    byte_column,
    input  logic [7:0]          byte_value,
    input  logic [IND_W-1:0]    first_individual,
    input  logic [IND_W-1:0]    second_individual,
    input  logic [SITE_W-1:0]   start_site,
    input  logic [SITE_W-1:0]   stop_site,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [COUNT_W-1:0]  het_count,
    input  logic [COUNT_W-1:0]  mismatch_count,
    input  logic                range_error,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data,
    output int                  mismatches,
    output int                  waiting,
    output int                  results_seen
);

    typedef struct packed {
        logic [COUNT_W-1:0] het;
        logic [COUNT_W-1:0] mis;
        logic               err;
    } tally_t;

    bit [7:0]    store_model [STORE_DEPTH];
    int unsigned stride_model;
    tally_t      tally_q [$];

    function automatic int unsigned clamp_stride(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_ROW_BYTES)
            return MAX_ROW_BYTES;
        return v;
    endfunction

    // flat memory: columns past the stride spill into the next row
    function automatic int unsigned flat_addr(int unsigned row, int unsigned col);
        return (row * stride_model + col) % STORE_DEPTH;
    endfunction

    function automatic tally_t count_het(logic [IND_W-1:0] ia, logic [IND_W-1:0] ib,
                                         logic [SITE_W-1:0] lo, logic [SITE_W-1:0] hi);
        tally_t      t;
        int unsigned ra;
        int unsigned rb;
        int unsigned het;
        int unsigned mis;
        logic [7:0]  ma;
        logic [7:0]  mb;
        t = '0;
        if (hi < lo)
        begin
            t.err = 1'b1;
            return t;
        end
        ra  = 2 * ia;
        rb  = 2 * ib;
        het = 0;
        mis = 0;
        for (int unsigned k = lo >> 3; k <= (hi >> 3); k++)
        begin
            ma = store_model[flat_addr(ra, k)] ^ store_model[flat_addr(ra + 1, k)];
            mb = store_model[flat_addr(rb, k)] ^ store_model[flat_addr(rb + 1, k)];
            het += $countones(ma | mb);
            mis += $countones(ma ^ mb);
        end
        t.het = het[COUNT_W-1:0];
        t.mis = mis[COUNT_W-1:0];
        return t;
    endfunction

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= 20)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        tally_t want;
        if (!rst_n)
        begin
            stride_model = MAX_ROW_BYTES;
            tally_q.delete();
            waiting = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (tally_q.size() == 0)
                    report($sformatf("result het=%0d mis=%0d err=%0d with nothing pending",
                                     het_count, mismatch_count, range_error));
                else
                begin
                    want = tally_q.pop_front();
                    if (het_count !== want.het)
                        report($sformatf("het_count %0d, expected %0d", het_count, want.het));
                    if (mismatch_count !== want.mis)
                        report($sformatf("mismatch_count %0d, expected %0d",
                                         mismatch_count, want.mis));
                    if (range_error !== want.err)
                        report($sformatf("range_error %0d, expected %0d", range_error, want.err));
                end
            end
            if (cfg_valid && cfg_ready)
                stride_model = clamp_stride(cfg_data);
            if (in_valid && in_ready)
            begin
                if (req_type == REQ_WRITE)
                    store_model[flat_addr(row_index, byte_column)] = byte_value;
                else
                    tally_q.push_back(count_het(first_individual, second_individual,
                                                start_site, stop_site));
            end
            waiting = tally_q.size();
        end
    end

endmodule

>>> dv/het_mismatch_counter_tb.sv
module het_mismatch_counter_tb;
    import hmc_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int LIMIT_CYCLES  = 1_500_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 160;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int NUM_PHASES    = 7;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                req_type;
    logic [ROW_W-1:0]    row_index;
    logic [COL_W-1:0]    byte_column;
    logic [7:0]          byte_value;
    logic [IND_W-1:0]    first_individual;
    logic [IND_W-1:0]    second_individual;
    logic [SITE_W-1:0]   start_site;
    logic [SITE_W-1:0]   stop_site;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [COUNT_W-1:0]  het_count;
    logic [COUNT_W-1:0]  mismatch_count;
    logic                range_error;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;

    int          chk_mismatches;
    int          chk_waiting;
    int          chk_results;

    bit          calm;
    bit          written [STORE_DEPTH];
    int unsigned stride_now;
    int          ready_left = 0;
    int          n_items;
    int          n_writes;
    int          n_queries;
    int          n_reversed;
    int          n_strides;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    het_mismatch_counter dut (.*);

    het_mismatch_counter_checker chk (
        .*,
        .mismatches   (chk_mismatches),
        .waiting      (chk_waiting),
        .results_seen (chk_results)
    );

    // result side: bursts of stall and of readiness, steady ready once calm
    always @(negedge clk)
    begin
        if (ready_left > 0)
            ready_left--;
        else if (calm)
            out_ready = 1'b1;
        else
        begin
            out_ready  = ($urandom_range(0, 99) < 35) ? 1'b0 : 1'b1;
            ready_left = $urandom_range(1, 16) - 1;
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned stim_addr(int unsigned row, int unsigned col);
        return (row * stride_now + col) % STORE_DEPTH;
    endfunction

    task automatic send_item(input logic rq, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic [7:0] val,
                             input logic [IND_W-1:0] ia, input logic [IND_W-1:0] ib,
                             input logic [SITE_W-1:0] lo, input logic [SITE_W-1:0] hi);
        int gap;
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_type          = rq;
        row_index         = row;
        byte_column       = col;
        byte_value        = val;
        first_individual  = ia;
        second_individual = ib;
        start_site        = lo;
        stop_site         = hi;
        in_valid          = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_items++;
    endtask

    task automatic write_byte(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                              input logic [7:0] val);
        send_item(REQ_WRITE, row, col, val,
                  IND_W'($urandom_range(0, 127)), IND_W'($urandom_range(0, 127)),
                  SITE_W'($urandom_range(0, 511)), SITE_W'($urandom_range(0, 511)));
        written[stim_addr(row, col)] = 1'b1;
        n_writes++;
    endtask

    task automatic query(input logic [IND_W-1:0] ia, input logic [IND_W-1:0] ib,
                         input logic [SITE_W-1:0] lo, input logic [SITE_W-1:0] hi);
        send_item(REQ_QUERY, ROW_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 63)),
                  8'($urandom_range(0, 255)), ia, ib, lo, hi);
        n_queries++;
        if (hi < lo)
            n_reversed++;
    endtask

    // fill every byte the query will read, refresh a few, then ask
    task automatic query_seq(input logic [IND_W-1:0] ia, input logic [IND_W-1:0] ib,
                             input logic [SITE_W-1:0] lo, input logic [SITE_W-1:0] hi);
        int unsigned rows [4];
        rows = '{2 * ia, 2 * ia + 1, 2 * ib, 2 * ib + 1};
        if (hi >= lo)
            for (int unsigned k = lo >> 3; k <= (hi >> 3); k++)
                foreach (rows[r])
                    if (!written[stim_addr(rows[r], k)] || $urandom_range(0, 99) < 4)
                        write_byte(ROW_W'(rows[r]), COL_W'(k), 8'($urandom_range(0, 255)));
        query(ia, ib, lo, hi);
    endtask

    function automatic logic [IND_W-1:0] pick_individual();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return (r < 5) ? 7'd0 : 7'd127;
        if (r < 55)
            return IND_W'($urandom_range(0, 5));
        return IND_W'($urandom_range(0, 127));
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (chk_waiting != 0)
            @(negedge clk);
        // a trailing write leaves no result behind, so give it time to land
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_stride(input logic [CFG_W-1:0] v);
        wait_idle();
        cfg_data  = v;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid  = 1'b0;
        stride_now = (v == 0) ? 1 : ((v > MAX_ROW_BYTES) ? MAX_ROW_BYTES : v);
        n_strides++;
    endtask

    task automatic random_phase(input int quota);
        int                stop_at;
        int                pick;
        int                shape;
        int                span;
        logic [IND_W-1:0]  ia;
        logic [IND_W-1:0]  ib;
        logic [SITE_W-1:0] lo;
        logic [SITE_W-1:0] hi;
        stop_at = n_items + quota;
        while (n_items < stop_at)
        begin
            pick = $urandom_range(0, 99);
            ia   = pick_individual();
            ib   = ($urandom_range(0, 99) < 10) ? ia : pick_individual();
            if (pick < 35)
                write_byte(ROW_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 63)),
                           8'($urandom_range(0, 255)));
            else if (pick < 43)
            begin
                lo = SITE_W'($urandom_range(1, 511));
                hi = SITE_W'($urandom_range(0, lo - 1));
                query(ia, ib, lo, hi);
            end
            else
            begin
                shape = $urandom_range(0, 99);
                if (shape < 95)
                begin
                    span = (shape < 80) ? $urandom_range(0, 31) : $urandom_range(0, 127);
                    lo   = SITE_W'($urandom_range(0, 511));
                    hi   = (lo + span > 511) ? 9'd511 : SITE_W'(lo + span);
                end
                else
                begin
                    lo = SITE_W'($urandom_range(0, 15));
                    hi = SITE_W'($urandom_range(496, 511));
                end
                query_seq(ia, ib, lo, hi);
            end
        end
    endtask

    initial
    begin
        int cfg_plan [NUM_PHASES];
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        req_type          = REQ_WRITE;
        row_index         = '0;
        byte_column       = '0;
        byte_value        = '0;
        first_individual  = '0;
        second_individual = '0;
        start_site        = '0;
        stop_site         = '0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        calm              = 1'b0;
        stride_now        = MAX_ROW_BYTES;
        n_items           = 0;
        n_writes          = 0;
        n_queries         = 0;
        n_reversed        = 0;
        n_strides         = 0;
        cfg_plan = '{127, 1, 0, $urandom_range(2, 63), 64, 63, $urandom_range(1, 64)};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extreme rows, first and last byte, rounding, reversed ranges
        write_byte(8'd0,   6'd0,  8'hFF);
        write_byte(8'd1,   6'd0,  8'h00);
        write_byte(8'd254, 6'd0,  8'hFF);
        write_byte(8'd255, 6'd0,  8'hFF);
        write_byte(8'd0,   6'd63, 8'hAA);
        write_byte(8'd1,   6'd63, 8'h55);
        write_byte(8'd254, 6'd63, 8'h0F);
        write_byte(8'd255, 6'd63, 8'h00);
        query(7'd0,   7'd127, 9'd0,   9'd7);
        query(7'd0,   7'd127, 9'd3,   9'd5);
        query(7'd0,   7'd127, 9'd504, 9'd511);
        query(7'd127, 7'd0,   9'd511, 9'd511);
        query(7'd0,   7'd0,   9'd0,   9'd0);
        query(7'd127, 7'd127, 9'd504, 9'd511);
        query(7'd0,   7'd127, 9'd511, 9'd0);
        query(7'd0,   7'd127, 9'd8,   9'd7);
        query(7'd5,   7'd9,   9'd300, 9'd299);
        write_byte(8'd255, 6'd63, 8'hFF);
        query(7'd127, 7'd0,   9'd504, 9'd511);

        foreach (cfg_plan[p])
        begin
            set_stride(CFG_W'(cfg_plan[p]));
            if (p == NUM_PHASES - 1)
                calm = 1'b1;
            random_phase(RANDOM_ITEMS / NUM_PHASES);
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (chk_waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d items: %0d byte writes, %0d count queries, %0d reversed",
                 n_items, n_writes, n_queries, n_reversed);
        $display("%0d results checked over %0d stride settings after reset",
                 chk_results, n_strides);
        if (chk_mismatches == 0 && chk_waiting == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
